### hw/rtl/cdp_pkg.sv
// shared types, constants and a fixed-point helper for the chlorophyll depth products
package cdp_pkg;

  localparam int LOG_STAGES = 24;
  localparam int POW_BITS   = 24;
  localparam int SQ_SUBS    = 8;
  localparam int SQ_ITERS   = 4;

  localparam logic [0:0] REG_PRODUCT_MODE = 1'd0;
  localparam logic [0:0] REG_BAD_VALUE    = 1'd1;

  localparam logic [1:0] MODE_SECCHI = 2'd1;
  localparam logic [1:0] MODE_INTEG  = 2'd2;

  localparam logic signed [23:0] Q168_MAX  = 24'sh7FFFFF;
  localparam logic signed [23:0] Q168_MIN  = -24'sh800000;
  localparam logic signed [23:0] CHL_LIMIT = 24'sd983040;

  localparam logic signed [35:0] LOG10_OF_2 = 36'sd1292913986;
  localparam logic signed [35:0] LOG2_OF_10 = 36'sd14267572527;
  localparam logic signed [35:0] ONE_MUL    = 36'sd1;

  localparam logic signed [35:0] ZEU_K0 = 36'sd25568477;
  localparam logic signed [35:0] ZEU_K1 = -36'sd7717519;
  localparam logic signed [35:0] ZEU_K2 = -36'sd8556;
  localparam logic signed [35:0] ZEU_K3 = 36'sd473117;
  localparam logic signed [35:0] ZSD_K0 = 36'sd142606336;
  localparam logic signed [35:0] ZSD_K1 = -36'sd211392922;
  localparam logic signed [35:0] ZSD_K2 = 36'sd123480310;
  localparam logic signed [35:0] ZSD_K3 = -36'sd23991419;

  typedef struct packed {
    logic signed [23:0] chl_value;
    logic               masked;
    logic               last_pixel;
  } cdp_in_t;

  typedef struct packed {
    logic signed [23:0] depth_result;
    logic               fail_flag;
    logic               warn_flag;
    logic               last_out;
  } cdp_out_t;

  typedef struct packed {
    logic        [22:0] chl;
    logic               fail;
    logic               warn;
    logic               last;
    logic signed [23:0] sd_res;
  } cdp_side_t;

  // signed product, rounded half away from zero, shifted right by sh
  function automatic logic signed [39:0] mulr(input logic signed [39:0] a,
                                              input logic signed [35:0] b,
                                              input int unsigned sh);
    logic        neg;
    logic [39:0] ua;
    logic [35:0] ub;
    logic [75:0] p;
    logic [75:0] r;
    neg = a[39] ^ b[35];
    ua = a[39] ? 40'(-a) : 40'(a);
    ub = b[35] ? 36'(-b) : 36'(b);
    p = 76'(ua) * 76'(ub);
    r = (p + (76'd1 << (sh - 1))) >> sh;
    mulr = neg ? -40'(r) : 40'(r);
  endfunction

endpackage

### hw/rtl/cdp_log2.sv
// log2 fraction pipeline: one squaring step per stage
module cdp_log2 import cdp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [30:0]           in_z,
  input  logic [4:0]            in_e,
  input  cdp_side_t             in_side,
  output logic                  out_vld,
  output logic [LOG_STAGES-1:0] out_frac,
  output logic [4:0]            out_e,
  output cdp_side_t             out_side
);

  logic                  vld_r  [LOG_STAGES];
  logic [30:0]           z_r    [LOG_STAGES];
  logic [LOG_STAGES-1:0] frac_r [LOG_STAGES];
  logic [4:0]            e_r    [LOG_STAGES];
  cdp_side_t             side_r [LOG_STAGES];

  for (genvar g = 0; g < LOG_STAGES; g++) begin : g_stage
    logic                  pv;
    logic [30:0]           pz;
    logic [LOG_STAGES-1:0] pf;
    logic [4:0]            pe;
    cdp_side_t             ps;
    logic [61:0]           sq;
    logic [31:0]           zz;
    logic [30:0]           z_nxt;
    logic [LOG_STAGES-1:0] frac_nxt;

    if (g == 0) begin : g_first
      assign pv = in_vld;
      assign pz = in_z;
      assign pf = '0;
      assign pe = in_e;
      assign ps = in_side;
    end else begin : g_rest
      assign pv = vld_r[g-1];
      assign pz = z_r[g-1];
      assign pf = frac_r[g-1];
      assign pe = e_r[g-1];
      assign ps = side_r[g-1];
    end

    always_comb begin
      sq = 62'(pz) * 62'(pz);
      zz = sq[61:30];
      z_nxt = zz[31] ? zz[31:1] : zz[30:0];
      frac_nxt = {pf[LOG_STAGES-2:0], zz[31]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= pv;
      end
      if (en) begin
        z_r[g]    <= z_nxt;
        frac_r[g] <= frac_nxt;
        e_r[g]    <= pe;
        side_r[g] <= ps;
      end
    end
  end

  assign out_vld  = vld_r[LOG_STAGES-1];
  assign out_frac = frac_r[LOG_STAGES-1];
  assign out_e    = e_r[LOG_STAGES-1];
  assign out_side = side_r[LOG_STAGES-1];

endmodule

### hw/rtl/cdp_pow2.sv
// 2^f pipeline: per fraction bit an optional doubling and a staged integer square root
module cdp_pow2 import cdp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [POW_BITS-1:0] in_f,
  input  logic signed [15:0]  in_n,
  input  cdp_side_t           in_side,
  output logic                out_vld,
  output logic [30:0]         out_v,
  output logic signed [15:0]  out_n,
  output cdp_side_t           out_side
);

  localparam int STAGES = POW_BITS * SQ_SUBS;

  logic                vld_r  [STAGES];
  logic [31:0]         v_r    [STAGES];
  logic [32:0]         rem_r  [STAGES];
  logic [30:0]         q_r    [STAGES];
  logic [POW_BITS-1:0] f_r    [STAGES];
  logic signed [15:0]  n_r    [STAGES];
  cdp_side_t           side_r [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    localparam int J = g / SQ_SUBS;
    localparam int S = g % SQ_SUBS;
    logic                pvl;
    logic [31:0]         pv;
    logic [32:0]         prem;
    logic [30:0]         pq;
    logic [POW_BITS-1:0] pf;
    logic signed [15:0]  pn;
    cdp_side_t           ps;
    logic [31:0]         vin;
    logic [34:0]         rem;
    logic [34:0]         remx;
    logic [34:0]         trial;
    logic [30:0]         q;
    logic [1:0]          pair;
    logic [31:0]         v_nxt;

    if (g == 0) begin : g_first
      assign pvl  = in_vld;
      assign pv   = 32'h4000_0000;
      assign prem = '0;
      assign pq   = '0;
      assign pf   = in_f;
      assign pn   = in_n;
      assign ps   = in_side;
    end else begin : g_rest
      assign pvl  = vld_r[g-1];
      assign pv   = v_r[g-1];
      assign prem = rem_r[g-1];
      assign pq   = q_r[g-1];
      assign pf   = f_r[g-1];
      assign pn   = n_r[g-1];
      assign ps   = side_r[g-1];
    end

    always_comb begin
      if (S == 0) begin
        vin = pf[J] ? {pv[30:0], 1'b0} : {1'b0, pv[30:0]};
        rem = '0;
        q   = '0;
      end else begin
        vin = pv;
        rem = {2'b00, prem};
        q   = pq;
      end
      for (int it = 0; it < SQ_ITERS; it++) begin
        if (S * SQ_ITERS + it <= 30) begin
          if (S * SQ_ITERS + it < 16) begin
            pair = 2'(vin >> (30 - 2 * (S * SQ_ITERS + it)));
          end else begin
            pair = 2'b00;
          end
          remx  = {rem[32:0], pair};
          trial = {2'b00, q, 2'b01};
          if (remx >= trial) begin
            rem = remx - trial;
            q   = {q[29:0], 1'b1};
          end else begin
            rem = remx;
            q   = {q[29:0], 1'b0};
          end
        end
      end
      v_nxt = (S == SQ_SUBS - 1) ? {1'b0, q} : vin;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= pvl;
      end
      if (en) begin
        v_r[g]    <= v_nxt;
        rem_r[g]  <= rem[32:0];
        q_r[g]    <= q;
        f_r[g]    <= pf;
        n_r[g]    <= pn;
        side_r[g] <= ps;
      end
    end
  end

  assign out_vld  = vld_r[STAGES-1];
  assign out_v    = v_r[STAGES-1][30:0];
  assign out_n    = n_r[STAGES-1];
  assign out_side = side_r[STAGES-1];

endmodule

### hw/rtl/chlorophyll_depth_products_top.sv
// top level of the chlorophyll depth products pipeline
//
//  channel  | handshake            | payload
//  in       | in_valid / in_ready  | in_data   (cdp_in_t)
//  out      | out_valid / out_ready| out_data  (cdp_out_t)
//  cfg      | cfg_we               | cfg_index, cfg_wdata
//
// one item per cycle sustained while the output is not stalled; stages: capture, 24 log2 squaring
// stages, log10, three cubic stages, exponent split, 192 square root stages
// (up to 4 root bits each), scale multiply and the output register
// synchronous active-low reset empties every stage and restores the registers
// a waiting result holds the whole pipeline; in_ready follows that stall
module chlorophyll_depth_products_top import cdp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  cdp_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output cdp_out_t    out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  logic               en;
  logic [1:0]         mode_r;
  logic signed [23:0] bad_r;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      bad_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRODUCT_MODE: mode_r <= cfg_wdata[1:0];
        REG_BAD_VALUE:    bad_r  <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // capture
  logic        a_vld_r;
  logic [30:0] a_z_r, a_z_nxt;
  logic [4:0]  a_e_r, a_e_nxt;
  cdp_side_t   a_side_r, a_side_nxt;

  always_comb begin
    logic [22:0] c;
    c = in_data.chl_value[22:0];
    a_e_nxt = '0;
    for (int b = 1; b < 23; b++) begin
      if (c[b]) a_e_nxt = 5'(b);
    end
    a_z_nxt = 31'(c) << (5'd30 - a_e_nxt);
    a_side_nxt.chl  = c;
    a_side_nxt.warn = in_data.chl_value > CHL_LIMIT;
    a_side_nxt.fail = in_data.masked || (in_data.chl_value <= 24'sd0) ||
                      ((mode_r == MODE_SECCHI) && (in_data.chl_value > CHL_LIMIT));
    a_side_nxt.last = in_data.last_pixel;
    a_side_nxt.sd_res = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
    if (en) begin
      a_z_r    <= a_z_nxt;
      a_e_r    <= a_e_nxt;
      a_side_r <= a_side_nxt;
    end
  end

  logic                  l_vld;
  logic [LOG_STAGES-1:0] l_frac;
  logic [4:0]            l_e;
  cdp_side_t             l_side;

  cdp_log2 u_log2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (a_vld_r),
    .in_z     (a_z_r),
    .in_e     (a_e_r),
    .in_side  (a_side_r),
    .out_vld  (l_vld),
    .out_frac (l_frac),
    .out_e    (l_e),
    .out_side (l_side)
  );

  // log10 and the three horner steps
  logic               x_vld_r, c1_vld_r, c2_vld_r, c3_vld_r;
  logic signed [35:0] x_r, x_nxt;
  logic signed [35:0] x1_r, x2_r;
  logic signed [35:0] eu1_r, eu1_nxt, sd1_r, sd1_nxt;
  logic signed [35:0] eu2_r, eu2_nxt, sd2_r, sd2_nxt;
  logic signed [35:0] eu3_r, eu3_nxt, sd3_r, sd3_nxt;
  cdp_side_t          x_side_r, c1_side_r, c2_side_r, c3_side_r;

  always_comb begin
    logic signed [39:0] lv;
    lv = ((40'(l_e) - 40'sd16) <<< 24) + 40'(l_frac);
    x_nxt   = 36'(mulr(lv, LOG10_OF_2, 32));
    eu1_nxt = 36'(40'(ZEU_K2) + mulr(40'(x_r), ZEU_K3, 24));
    sd1_nxt = 36'(40'(ZSD_K2) + mulr(40'(x_r), ZSD_K3, 24));
    eu2_nxt = 36'(40'(ZEU_K1) + mulr(40'(x1_r), eu1_r, 24));
    sd2_nxt = 36'(40'(ZSD_K1) + mulr(40'(x1_r), sd1_r, 24));
    eu3_nxt = 36'(40'(ZEU_K0) + mulr(40'(x2_r), eu2_r, 24));
    sd3_nxt = 36'(40'(ZSD_K0) + mulr(40'(x2_r), sd2_r, 24));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r  <= 1'b0;
      c1_vld_r <= 1'b0;
      c2_vld_r <= 1'b0;
      c3_vld_r <= 1'b0;
    end else if (en) begin
      x_vld_r  <= l_vld;
      c1_vld_r <= x_vld_r;
      c2_vld_r <= c1_vld_r;
      c3_vld_r <= c2_vld_r;
    end
    if (en) begin
      x_r       <= x_nxt;
      x_side_r  <= l_side;
      eu1_r     <= eu1_nxt;
      sd1_r     <= sd1_nxt;
      x1_r      <= x_r;
      c1_side_r <= x_side_r;
      eu2_r     <= eu2_nxt;
      sd2_r     <= sd2_nxt;
      x2_r      <= x1_r;
      c2_side_r <= c1_side_r;
      eu3_r     <= eu3_nxt;
      sd3_r     <= sd3_nxt;
      c3_side_r <= c2_side_r;
    end
  end

  // exponent split and secchi rounding
  logic                t_vld_r;
  logic [POW_BITS-1:0] t_f_r, t_f_nxt;
  logic signed [15:0]  t_n_r, t_n_nxt;
  cdp_side_t           t_side_r, t_side_nxt;

  always_comb begin
    logic signed [39:0] t;
    logic signed [39:0] sd;
    t       = mulr(40'(eu3_r), LOG2_OF_10, 32);
    t_n_nxt = 16'(t >>> 24);
    t_f_nxt = t[23:0];
    sd      = mulr(40'(sd3_r), ONE_MUL, 16);
    t_side_nxt = c3_side_r;
    if (sd > 40'(Q168_MAX)) begin
      t_side_nxt.sd_res = Q168_MAX;
    end else if (sd < 40'(Q168_MIN)) begin
      t_side_nxt.sd_res = Q168_MIN;
    end else begin
      t_side_nxt.sd_res = 24'(sd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else if (en) begin
      t_vld_r <= c3_vld_r;
    end
    if (en) begin
      t_f_r    <= t_f_nxt;
      t_n_r    <= t_n_nxt;
      t_side_r <= t_side_nxt;
    end
  end

  logic               w_vld;
  logic [30:0]        w_v;
  logic signed [15:0] w_n;
  cdp_side_t          w_side;

  cdp_pow2 u_pow2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (t_vld_r),
    .in_f     (t_f_r),
    .in_n     (t_n_r),
    .in_side  (t_side_r),
    .out_vld  (w_vld),
    .out_v    (w_v),
    .out_n    (w_n),
    .out_side (w_side)
  );

  // scale product in integrated mode, plain mantissa otherwise
  logic               p_vld_r;
  logic [53:0]        p_r, p_nxt;
  logic signed [15:0] s_r, s_nxt;
  cdp_side_t          p_side_r;

  always_comb begin
    if (mode_r == MODE_INTEG) begin
      p_nxt = 54'(w_v) * 54'(w_side.chl);
      s_nxt = w_n - 16'sd38;
    end else begin
      p_nxt = 54'(w_v);
      s_nxt = w_n - 16'sd22;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= w_vld;
    end
    if (en) begin
      p_r      <= p_nxt;
      s_r      <= s_nxt;
      p_side_r <= w_side;
    end
  end

  // output register
  logic     o_vld_r;
  cdp_out_t o_r, o_nxt;

  always_comb begin
    logic [5:0]         sh;
    logic [63:0]        r;
    logic signed [23:0] res;
    logic signed [15:0] neg_s;
    neg_s = -s_r;
    sh = neg_s[5:0];
    r  = (64'(p_r) + (64'd1 << (sh - 6'd1))) >> sh;
    if (s_r >= 16'sd0) begin
      res = Q168_MAX;
    end else if (s_r <= -16'sd64) begin
      res = '0;
    end else if (r > 64'(Q168_MAX)) begin
      res = Q168_MAX;
    end else begin
      res = 24'(r);
    end
    if (mode_r == MODE_SECCHI) res = p_side_r.sd_res;
    o_nxt.depth_result = p_side_r.fail ? bad_r : res;
    o_nxt.fail_flag    = p_side_r.fail;
    o_nxt.warn_flag    = p_side_r.warn;
    o_nxt.last_out     = p_side_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= p_vld_r;
    end
    if (en) begin
      o_r <= o_nxt;
    end
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_r;

endmodule

### hw/rtl/cdp_checker.sv
// port-level checker for the chlorophyll depth products top level, with its bind
module cdp_checker import cdp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input cdp_in_t     in_data,
  input logic        out_valid,
  input logic        out_ready,
  input cdp_out_t    out_data,
  input logic        cfg_we,
  input logic [0:0]  cfg_index,
  input logic [23:0] cfg_wdata
);

  logic [1:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
    end else if (cfg_we && cfg_index == REG_PRODUCT_MODE) begin
      mode_r <= cfg_wdata[1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item after reset");

  a_secchi_warn_fails: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r == MODE_SECCHI && out_data.warn_flag |-> out_data.fail_flag)
    else $error("secchi item above limit not failed");

  a_depth_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r != MODE_SECCHI && !out_data.fail_flag
      |-> !out_data.depth_result[23])
    else $error("negative depth result");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");

endmodule

bind chlorophyll_depth_products_top cdp_checker u_cdp_checker (.*);

### tb/sv/chlorophyll_depth_products_top_tb.sv
// self-checking testbench for the chlorophyll depth products pipeline
`timescale 1ns / 1ps

module chlorophyll_depth_products_top_tb;
  import cdp_pkg::*;

  localparam logic [1:0] MODE_EUPHOTIC = 2'd0;
  localparam logic [1:0] MODE_SPARE    = 2'd3;
  localparam longint ONE_Q24    = 64'sd16777216;
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     DRAIN_WAIT  = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  cdp_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  cdp_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_PRODUCT_MODE;
  logic [23:0] cfg_wdata = '0;

  logic [1:0]  mode_now = MODE_EUPHOTIC;
  logic [23:0] bad_now = '0;
  cdp_out_t    depth_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  typedef struct {
    logic [1:0]  mode;
    logic [23:0] bad;
    cdp_in_t     pix;
    bit          typed;
    cdp_out_t    want;
  } dir_row_t;

  chlorophyll_depth_products_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // signed product rounded half away from zero
  function automatic longint round_mul(longint a, longint b, int sh);
    logic [127:0] ua, ub, p;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 128'(-a) : 128'(a);
    ub = (b < 0) ? 128'(-b) : 128'(b);
    p = ((ua * ub) + (128'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] a);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint chl_log10(longint chl);
    logic [63:0] c, z;
    int e;
    longint frac, l;
    c = chl;
    e = 0;
    frac = 0;
    while (e < 22 && (c >> (e + 1)) != 0) e++;
    z = c << (30 - e);
    for (int i = 0; i < 24; i++) begin
      z = (z * z) >> 30;
      frac = frac << 1;
      if (z >= (64'd1 << 31)) begin
        frac = frac | 1;
        z = z >> 1;
      end
    end
    l = longint'(e - 16) * ONE_Q24 + frac;
    return round_mul(l, LOG10_OF_2, 32);
  endfunction

  function automatic longint horner3(longint k0, longint k1, longint k2, longint k3,
                                     longint x);
    longint p;
    p = k3;
    p = k2 + round_mul(x, p, 24);
    p = k1 + round_mul(x, p, 24);
    p = k0 + round_mul(x, p, 24);
    return p;
  endfunction

  // returns the q.30 mantissa of 10^y, binary exponent in n
  function automatic logic [63:0] pow10_mant(longint y, output longint n);
    longint t;
    logic [63:0] f, v;
    t = round_mul(y, LOG2_OF_10, 32);
    if (t >= 0) n = t / ONE_Q24;
    else n = -((-t + ONE_Q24 - 1) / ONE_Q24);
    f = t - n * ONE_Q24;
    v = 64'd1 << 30;
    for (int i = 0; i < 24; i++) begin
      if (f[i]) v = v << 1;
      v = int_sqrt(v << 30);
    end
    return v;
  endfunction

  function automatic logic [23:0] sat_scale(logic [63:0] p, longint s);
    logic [63:0] r;
    if (s >= 0) return Q168_MAX;
    if (s <= -64) return 24'd0;
    r = (p + (64'd1 << (-s - 1))) >> (-s);
    if (r > 64'(Q168_MAX)) return Q168_MAX;
    return r[23:0];
  endfunction

  function automatic cdp_out_t depth_of(cdp_in_t pix);
    cdp_out_t o;
    longint chl, x, res, n;
    logic [63:0] v;
    chl = pix.chl_value;
    o.warn_flag = chl > longint'(CHL_LIMIT);
    o.fail_flag = pix.masked || chl <= 0 || (mode_now == MODE_SECCHI && o.warn_flag);
    o.last_out = pix.last_pixel;
    if (o.fail_flag) begin
      o.depth_result = bad_now;
    end else begin
      x = chl_log10(chl);
      if (mode_now == MODE_SECCHI) begin
        res = round_mul(horner3(ZSD_K0, ZSD_K1, ZSD_K2, ZSD_K3, x), ONE_MUL, 16);
        if (res > longint'(Q168_MAX)) res = Q168_MAX;
        if (res < longint'(Q168_MIN)) res = Q168_MIN;
        o.depth_result = res[23:0];
      end else begin
        v = pow10_mant(horner3(ZEU_K0, ZEU_K1, ZEU_K2, ZEU_K3, x), n);
        if (mode_now == MODE_INTEG) o.depth_result = sat_scale(v * 64'(chl), n - 38);
        else o.depth_result = sat_scale(v, n - 22);
      end
    end
    return o;
  endfunction

  task automatic report(string what, logic [23:0] want, logic [23:0] got);
    $display("mismatch %s: expected %0h got %0h at cycle %0d", what, want, got, cycles);
    mismatches++;
  endtask

  // output checker
  always @(posedge clk) begin
    cdp_out_t w;
    if (rst_n && out_valid && out_ready) begin
      if (depth_q.size() == 0) begin
        report("unexpected item", 24'd0, out_data.depth_result);
      end else begin
        w = depth_q.pop_front();
        if (out_data.depth_result !== w.depth_result)
          report("depth_result", w.depth_result, out_data.depth_result);
        if (out_data.fail_flag !== w.fail_flag)
          report("fail_flag", w.fail_flag, out_data.fail_flag);
        if (out_data.warn_flag !== w.warn_flag)
          report("warn_flag", w.warn_flag, out_data.warn_flag);
        if (out_data.last_out !== w.last_out)
          report("last_out", w.last_out, out_data.last_out);
      end
    end
  end

  // receiver with random stalls and one long hold
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic drain();
    while (depth_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(logic [0:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_PRODUCT_MODE) mode_now = val[1:0];
    else bad_now = val;
  endtask

  task automatic set_config(logic [1:0] mode, logic [23:0] bad);
    in_valid <= 1'b0;
    drain();
    @(posedge clk);
    set_reg(REG_PRODUCT_MODE, 24'(mode));
    set_reg(REG_BAD_VALUE, bad);
    cfg_we <= 1'b0;
  endtask

  task automatic send(cdp_in_t pix, bit typed, cdp_out_t want);
    int gap;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pix;
    do @(posedge clk); while (!in_ready);
    depth_q.push_back(typed ? want : depth_of(pix));
  endtask

  function automatic logic [23:0] rand_chl();
    int e;
    logic [23:0] v;
    case ($urandom_range(0, 11))
      0: v = {1'b1, 23'($urandom)};
      1: v = 24'd0;
      2: v = 24'(CHL_LIMIT) + 24'($urandom_range(0, 4)) - 24'd2;
      3: v = 24'($urandom_range(1, 15));
      default: begin
        e = $urandom_range(0, 22);
        v = (24'd1 << e) | (24'($urandom) & ((24'd1 << e) - 24'd1));
      end
    endcase
    return v;
  endfunction

  initial begin
    dir_row_t rows[$];
    cdp_in_t pix;
    logic [1:0] mode;
    logic [23:0] bad;
    int phase_len;
    int sent;

    rows = '{
      '{MODE_EUPHOTIC, 24'd0, '{24'sd65536, 1'b0, 1'b0}, 1'b0, '0},
      '{MODE_EUPHOTIC, 24'd0, '{24'sd1, 1'b0, 1'b1}, 1'b0, '0},
      '{MODE_EUPHOTIC, 24'd0, '{24'sd8388607, 1'b0, 1'b0}, 1'b0, '0},
      '{MODE_EUPHOTIC, 24'd0, '{24'sd983040, 1'b0, 1'b0}, 1'b0, '0},
      '{MODE_EUPHOTIC, 24'd0, '{24'sd983041, 1'b0, 1'b1}, 1'b0, '0},
      '{MODE_EUPHOTIC, 24'd0, '{24'sd0, 1'b0, 1'b0}, 1'b1, '{24'sd0, 1'b1, 1'b0, 1'b0}},
      '{MODE_EUPHOTIC, 24'd0, '{-24'sd8388608, 1'b0, 1'b1}, 1'b1,
        '{24'sd0, 1'b1, 1'b0, 1'b1}},
      '{MODE_EUPHOTIC, 24'h7FFFFF, '{24'sd65536, 1'b1, 1'b0}, 1'b1,
        '{24'sh7FFFFF, 1'b1, 1'b0, 1'b0}},
      '{MODE_EUPHOTIC, 24'h7FFFFF, '{24'sd8388607, 1'b1, 1'b1}, 1'b1,
        '{24'sh7FFFFF, 1'b1, 1'b1, 1'b1}},
      '{MODE_SECCHI, 24'h800000, '{24'sd65536, 1'b0, 1'b0}, 1'b1,
        '{24'sd2176, 1'b0, 1'b0, 1'b0}},
      '{MODE_SECCHI, 24'h800000, '{24'sd1310720, 1'b0, 1'b1}, 1'b1,
        '{-24'sd8388608, 1'b1, 1'b1, 1'b1}},
      '{MODE_SECCHI, 24'h800000, '{24'sd983040, 1'b0, 1'b0}, 1'b0, '0},
      '{MODE_SECCHI, 24'h800000, '{24'sd1, 1'b0, 1'b0}, 1'b0, '0},
      '{MODE_SECCHI, 24'h800000, '{24'sd6553, 1'b0, 1'b0}, 1'b0, '0},
      '{MODE_SECCHI, 24'h800000, '{-24'sd1, 1'b0, 1'b0}, 1'b1,
        '{-24'sd8388608, 1'b1, 1'b0, 1'b0}},
      '{MODE_INTEG, 24'h123456, '{24'sd65536, 1'b0, 1'b1}, 1'b0, '0},
      '{MODE_INTEG, 24'h123456, '{24'sd8388607, 1'b0, 1'b0}, 1'b0, '0},
      '{MODE_INTEG, 24'h123456, '{24'sd1, 1'b0, 1'b0}, 1'b0, '0},
      '{MODE_INTEG, 24'h123456, '{24'sd65536, 1'b1, 1'b0}, 1'b1,
        '{24'sh123456, 1'b1, 1'b0, 1'b0}},
      '{MODE_SPARE, 24'h000001, '{24'sd65536, 1'b0, 1'b0}, 1'b0, '0},
      '{MODE_SPARE, 24'h000001, '{24'sd3276800, 1'b0, 1'b1}, 1'b0, '0}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].mode != mode_now || rows[i].bad != bad_now)
        set_config(rows[i].mode, rows[i].bad);
      send(rows[i].pix, rows[i].typed, rows[i].want);
    end

    sent = 0;
    for (int ph = 0; sent < 1950; ph++) begin
      mode = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: bad = 24'h800000;
        1: bad = 24'h7FFFFF;
        default: bad = 24'($urandom);
      endcase
      set_config(mode, bad);
      if (ph == 2) hold_req = 1'b1;
      quiet = (sent >= 1600);
      // keep offering items through the long receiver hold
      phase_len = (ph == 2) ? 400 : $urandom_range(60, 200);
      for (int k = 0; k < phase_len && sent < 1950; k++) begin
        pix.chl_value = rand_chl();
        pix.masked = ($urandom_range(0, 7) == 0);
        pix.last_pixel = 1'($urandom);
        send(pix, 1'b0, '0);
        sent++;
        if (ph == 4 && k == 50) begin
          in_valid <= 1'b0;
          drain();
        end
      end
    end
    in_valid <= 1'b0;

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && depth_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
